>>> hdl/srr_pkg.sv
package srr_pkg;

  localparam int WINDOW       = 32;
  localparam int SEQ_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_BITS    = $clog2(WINDOW);

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [SLOT_BITS-1:0]    slot_idx_t;

  // packet kinds
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    RESP_ACK           = 3'd0,
    RESP_NACK_TIMEOUT  = 3'd1,
    RESP_NACK_CHECKSUM = 3'd2,
    RESP_DELIVER       = 3'd3,
    RESP_END           = 3'd4
  } resp_t;

  // slot store requests from the control
  typedef struct packed {
    logic      wr_en;
    slot_idx_t wr_idx;
    payload_t  wr_data;
    logic      rd_en;
    slot_idx_t rd_idx;
    logic      clr_en;
    slot_idx_t clr_idx;
  } slot_req_t;

  // slot of a sequence number: seq modulo WINDOW (WINDOW is a power of two)
  function automatic slot_idx_t slot_of(seq_t s);
    return s[SLOT_BITS-1:0];
  endfunction

endpackage

>>> hdl/srr_slot_store.sv
module srr_slot_store (
  input  logic                          clk,
  input  logic                          rst,
  input  srr_pkg::slot_req_t            req,
  output srr_pkg::payload_t             rd_data,
  output logic [srr_pkg::WINDOW-1:0]    valid
);
  import srr_pkg::*;

  payload_t mem [WINDOW];

  // payload RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_idx];
    end
  end

  // occupancy bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_idx] <= 1'b1;
      end
      if (req.clr_en) begin
        valid[req.clr_idx] <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/selective_repeat_reorder_receiver.sv
// Selective-repeat reorder receiver. A packet word is taken when start is
// high and busy is low; results appear one per cycle on the result ports,
// each for a single cycle and marked by strobe, and the receiver of them
// cannot stall the block, so it must take a word whenever strobe is high.
// The first result of a packet is registered and shows in the cycle after
// it is taken. End, timeout, bad-checksum and out-of-order or stale data
// packets give one result and leave busy low, so a new packet can follow in
// the next cycle. An in-order data packet gives an ACK, its own delivery and
// one delivery per buffered successor, 2 + D results in all; busy stays high
// while that delivery and the D drains run, D being the number of slots
// drained (at most WINDOW-1), one slot per cycle, set by the single read port
// of the slot RAM. last marks the final result of each packet. Unused opcode
// 3 gives no result and changes no state, though seq_out takes its seq.
module selective_repeat_reorder_receiver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  srr_pkg::seq_t               seq,
  input  logic                        checksum_ok,
  input  srr_pkg::payload_t           payload,
  output logic                        strobe,
  output logic [2:0]                  response,
  output srr_pkg::seq_t               seq_out,
  output srr_pkg::payload_t           payload_out,
  output logic                        last
);
  import srr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_DELIVER = 3'b010,   // emit payload of the in-order packet
    ST_DRAIN   = 3'b100    // emit buffered successors from the RAM
  } state_t;

  state_t    state, state_next;
  seq_t      expected, expected_next;
  payload_t  held, held_next;
  resp_t     resp, resp_next;
  logic      strobe_next;
  seq_t      seq_out_next;
  payload_t  payload_out_next;
  logic      last_next;

  slot_req_t          req;
  payload_t           rd_data;
  logic [WINDOW-1:0]  valid;

  seq_t      seq_gap;
  logic      in_window;
  seq_t      succ;
  logic      succ_valid;

  srr_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data),
    .valid   (valid)
  );

  assign seq_gap    = seq - expected;
  assign in_window  = seq_gap < SEQ_BITS'(WINDOW);
  assign succ       = expected + 1'b1;
  assign succ_valid = valid[slot_of(succ)];

  assign busy     = (state != ST_IDLE);
  assign response = resp;

  always_comb begin
    state_next       = state;
    expected_next    = expected;
    held_next        = held;
    strobe_next      = 1'b0;
    resp_next        = RESP_ACK;
    seq_out_next     = seq_out;
    payload_out_next = '0;
    last_next        = 1'b0;
    req              = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          seq_out_next = seq;
          unique case (opcode)
            OP_END: begin
              strobe_next = 1'b1;
              resp_next   = RESP_END;
              last_next   = 1'b1;
            end
            OP_TIMEOUT: begin
              strobe_next = 1'b1;
              resp_next   = RESP_NACK_TIMEOUT;
              last_next   = 1'b1;
            end
            OP_DATA: begin
              strobe_next = 1'b1;
              if (!checksum_ok) begin
                resp_next = RESP_NACK_CHECKSUM;
                last_next = 1'b1;
              end else if (seq_gap == '0) begin
                // in order: ACK now, delivery and drain follow
                resp_next  = RESP_ACK;
                held_next  = payload;
                state_next = ST_DELIVER;
              end else begin
                resp_next = RESP_ACK;
                last_next = 1'b1;
                // ahead inside the window: buffer unless slot taken
                if (in_window && !valid[slot_of(seq)]) begin
                  req.wr_en   = 1'b1;
                  req.wr_idx  = slot_of(seq);
                  req.wr_data = payload;
                end
              end
            end
            default: begin
              // unused opcode: no result
            end
          endcase
        end
      end

      ST_DELIVER, ST_DRAIN: begin
        strobe_next      = 1'b1;
        resp_next        = RESP_DELIVER;
        seq_out_next     = expected;
        payload_out_next = (state == ST_DELIVER) ? held : rd_data;
        last_next        = !succ_valid;
        expected_next    = succ;
        if (succ_valid) begin
          // fetch and free the next slot; data lands next cycle
          req.rd_en   = 1'b1;
          req.rd_idx  = slot_of(succ);
          req.clr_en  = 1'b1;
          req.clr_idx = slot_of(succ);
          state_next  = ST_DRAIN;
        end else begin
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      expected <= '0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      expected <= expected_next;
      strobe   <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    held        <= held_next;
    resp        <= resp_next;
    seq_out     <= seq_out_next;
    payload_out <= payload_out_next;
    last        <= last_next;
  end

endmodule
